@@ rtl/motor_safety_monitor_top_defines.svh @@
// ----------------------------------------------------------------------------
// Motor safety monitor assertion macros
// Shared concurrent assertion forms, clocked on clk and idle while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MOTOR_SAFETY_MONITOR_TOP_DEFINES_SVH
`define MOTOR_SAFETY_MONITOR_TOP_DEFINES_SVH

// Same-cycle implication
`define MSM_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define MSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/msm_pkg.sv @@
// ----------------------------------------------------------------------------
// msm_pkg
// Widths, register indexes and lane/merge types of the motor safety monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msm_pkg;

	localparam int SPEED_W  = 16;
	localparam int COUNT_W  = 8;
	localparam int N_LANES  = 4;
	localparam int LIMIT_W  = 15;
	localparam int IMBAL_W  = 16;
	localparam int ELIM_W   = 8;
	localparam int IDX_W    = 3;
	localparam int CFG_W    = 16;
	localparam int IN_W     = 160;
	localparam int OUT_W    = 144;

	localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

	// Register reset values
	localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST     = 15'd3215;
	localparam logic [LIMIT_W-1:0] ALTITUDE_LIMIT_RST  = 15'd1600;
	localparam logic [LIMIT_W-1:0] SPEED_MAX_RST       = 15'd25600;
	localparam logic [IMBAL_W-1:0] IMBALANCE_LIMIT_RST = 16'd7680;
	localparam logic [ELIM_W-1:0]  ERROR_LIMIT_RST     = 8'd10;

	typedef enum logic [IDX_W-1:0] {
		REG_ANGLE_LIMIT     = 3'd0,
		REG_ALTITUDE_LIMIT  = 3'd1,
		REG_SPEED_MAX       = 3'd2,
		REG_IMBALANCE_LIMIT = 3'd3,
		REG_ERROR_LIMIT     = 3'd4
	} reg_idx_t;

	// Findings of one speed lane
	typedef struct packed {
		logic range_bad;
		logic dev_bad;
	} lane_flag_t;

	// Item-wide findings from the first stage
	typedef struct packed {
		logic limit_bad;
		logic stop;
	} item_check_t;

	// Merge outcome
	typedef struct packed {
		logic fault;
		logic shut;
	} verdict_t;

endpackage

`default_nettype wire

@@ rtl/msm_lane.sv @@
// ----------------------------------------------------------------------------
// msm_lane
// One motor speed lane: range check and clamp in stage 1, deviation from the
// mean against the imbalance limit in stage 2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msm_lane (
	input  wire                                 clk,
	input  wire                                 load,
	input  wire logic signed [msm_pkg::SPEED_W-1:0] speed,
	input  wire logic [msm_pkg::LIMIT_W-1:0]    speed_max,
	input  wire logic signed [msm_pkg::SPEED_W-1:0] mean,
	input  wire logic [msm_pkg::IMBAL_W-1:0]    imbalance_limit,
	output logic [msm_pkg::LIMIT_W-1:0]         clamp,
	output msm_pkg::lane_flag_t                 flags
);
	import msm_pkg::*;

	logic signed [SPEED_W-1:0] speed_s1;
	logic [LIMIT_W-1:0]        clamp_s1;
	logic                      range_bad_s1;
	logic                      range_bad;
	logic [LIMIT_W-1:0]        clamp_d;
	logic signed [SPEED_W:0]   diff;
	logic [SPEED_W:0]          mag;

	// Check range and clamp to 0..speed_max
	always_comb begin
		range_bad = speed[SPEED_W-1] || (speed[LIMIT_W-1:0] > speed_max);
		if (speed[SPEED_W-1]) begin
			clamp_d = '0;
		end else if (speed[LIMIT_W-1:0] > speed_max) begin
			clamp_d = speed_max;
		end else begin
			clamp_d = speed[LIMIT_W-1:0];
		end
	end

	// Hold lane payload for stage 2
	always_ff @(posedge clk) begin
		if (load) begin
			speed_s1     <= speed;
			clamp_s1     <= clamp_d;
			range_bad_s1 <= range_bad;
		end
	end

	// Compare absolute deviation from the mean
	always_comb begin
		diff = {speed_s1[SPEED_W-1], speed_s1} - {mean[SPEED_W-1], mean};
		mag  = diff[SPEED_W] ? (SPEED_W+1)'(-diff) : diff;
		flags.range_bad = range_bad_s1;
		flags.dev_bad   = mag > {1'b0, imbalance_limit};
	end

	assign clamp = clamp_s1;

endmodule

`default_nettype wire

@@ rtl/msm_merge.sv @@
// ----------------------------------------------------------------------------
// msm_merge
// Combine lane and item findings into a fault, keep the saturating fault
// counter and decide shutdown.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "motor_safety_monitor_top_defines.svh"

module msm_merge (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          en,
	input  wire msm_pkg::lane_flag_t     lane_flags [msm_pkg::N_LANES],
	input  wire msm_pkg::item_check_t    chk,
	input  wire logic [msm_pkg::ELIM_W-1:0] error_limit,
	output msm_pkg::verdict_t            verdict
);
	import msm_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] cnt_inc;
	logic [COUNT_W-1:0] count_d;
	logic               speed_bad;
	logic               imbal_bad;
	logic               fault;
	logic               shut;

	// Merge lane findings
	always_comb begin
		speed_bad = 1'b0;
		imbal_bad = 1'b0;
		for (int i = 0; i < N_LANES; i++) begin
			speed_bad = speed_bad | lane_flags[i].range_bad;
			imbal_bad = imbal_bad | lane_flags[i].dev_bad;
		end
		fault = speed_bad | imbal_bad | chk.limit_bad | chk.stop;
	end

	// Advance counter and decide shutdown
	always_comb begin
		cnt_inc = (count_q != CNT_MAX) ? count_q + 1'b1 : count_q;
		shut    = fault && ((cnt_inc >= COUNT_W'(error_limit)) || chk.stop);
		if (fault) begin
			count_d = cnt_inc;
		end else if (count_q != '0) begin
			count_d = count_q - 1'b1;
		end else begin
			count_d = count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_d;
		end
	end

	assign verdict.fault = fault;
	assign verdict.shut  = shut;

	`MSM_ASSERT_NEXT(a_cnt_hold, !en, $stable(count_q), "fault count moved without an item")
	`MSM_ASSERT_NEXT(a_cnt_up, en && fault && (count_q != CNT_MAX), count_q == $past(count_q) + 1'b1, "fault count did not step up")
	`MSM_ASSERT_NEXT(a_cnt_down, en && !fault && (count_q != '0), count_q == $past(count_q) - 1'b1, "fault count did not step down")
	`MSM_ASSERT(a_shut_clean, en && !fault, !shut, "shutdown on a clean item")

endmodule

`default_nettype wire

@@ rtl/motor_safety_monitor_top.sv @@
// An accepted beat reaches m_tvalid via the input stage and output registers.
// One beat per cycle while m_tready allows; fault counter updates once per beat in msm_merge.
// Backpressure on m_tready stalls both stages; s_tready stays high while a slot is free.
// Reset (arst_n low): pipeline empties, fault count clears, limits return to their defaults.
// cfg_ready is always high; writes to an unknown index are dropped.
// ----------------------------------------------------------------------------
// motor_safety_monitor_top
// Motor safety monitor: four speed lanes plus attitude/altitude checks,
// merged into a fault counter that forces shutdown of the outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "motor_safety_monitor_top_defines.svh"

module motor_safety_monitor_top (
	input  wire                               clk,
	input  wire                               arst_n,
	// speed_front_left, speed_front_right, speed_rear_left, speed_rear_right,
	// roll_angle, pitch_angle, altitude, velocity_x, velocity_y, velocity_z
	input  wire logic [msm_pkg::IN_W-1:0]     s_tdata,
	// stop_request
	input  wire logic                         s_tuser,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	// out_front_left, out_front_right, out_rear_left, out_rear_right,
	// out_roll, out_pitch, out_vel_x, out_vel_y, out_vel_z, zero pad
	output logic [msm_pkg::OUT_W-1:0]         m_tdata,
	// shutdown
	output logic                              m_tuser,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [msm_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [msm_pkg::CFG_W-1:0]    cfg_data
);
	import msm_pkg::*;

	// Configuration registers
	logic [LIMIT_W-1:0] angle_limit_q;
	logic [LIMIT_W-1:0] altitude_limit_q;
	logic [LIMIT_W-1:0] speed_max_q;
	logic [IMBAL_W-1:0] imbalance_limit_q;
	logic [ELIM_W-1:0]  error_limit_q;

	// Stage 1
	logic                      v_s1;
	logic signed [SPEED_W+1:0] sum_s1;
	logic [SPEED_W-1:0]        roll_s1, pitch_s1, vx_s1, vy_s1, vz_s1;
	item_check_t               chk_s1;

	// Output register
	logic                      out_valid_q;
	logic [LIMIT_W-1:0]        out_speed_q [N_LANES];
	logic [SPEED_W-1:0]        out_roll_q, out_pitch_q, out_vx_q, out_vy_q, out_vz_q;
	logic                      out_shut_q;

	logic                      out_ready;
	logic                      load_s1;
	logic                      load_out;
	logic signed [SPEED_W-1:0] speed_in [N_LANES];
	logic [LIMIT_W-1:0]        clamp [N_LANES];
	lane_flag_t                lane_flags [N_LANES];
	logic signed [SPEED_W-1:0] mean;
	logic signed [SPEED_W+1:0] sum_d;
	logic signed [SPEED_W:0]   roll_x, pitch_x, alt_x, lim_x, lim_neg, alt_lim_x;
	item_check_t               chk_d;
	verdict_t                  verdict;

	// Handshake: each stage moves when the next one has room
	assign out_ready = !out_valid_q || m_tready;
	assign s_tready  = !v_s1 || out_ready;
	assign load_s1   = s_tvalid && s_tready;
	assign load_out  = v_s1 && out_ready;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_limit_q     <= ANGLE_LIMIT_RST;
			altitude_limit_q  <= ALTITUDE_LIMIT_RST;
			speed_max_q       <= SPEED_MAX_RST;
			imbalance_limit_q <= IMBALANCE_LIMIT_RST;
			error_limit_q     <= ERROR_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ANGLE_LIMIT:     angle_limit_q     <= cfg_data[LIMIT_W-1:0];
				REG_ALTITUDE_LIMIT:  altitude_limit_q  <= cfg_data[LIMIT_W-1:0];
				REG_SPEED_MAX:       speed_max_q       <= cfg_data[LIMIT_W-1:0];
				REG_IMBALANCE_LIMIT: imbalance_limit_q <= cfg_data[IMBAL_W-1:0];
				REG_ERROR_LIMIT:     error_limit_q     <= cfg_data[ELIM_W-1:0];
				default: ;
			endcase
		end
	end

	// Unpack speeds and sum them
	always_comb begin
		sum_d = '0;
		for (int i = 0; i < N_LANES; i++) begin
			speed_in[i] = s_tdata[i*SPEED_W +: SPEED_W];
			sum_d = sum_d + {{2{speed_in[i][SPEED_W-1]}}, speed_in[i]};
		end
	end

	// Check attitude and altitude limits
	always_comb begin
		roll_x    = {s_tdata[5*SPEED_W-1], s_tdata[4*SPEED_W +: SPEED_W]};
		pitch_x   = {s_tdata[6*SPEED_W-1], s_tdata[5*SPEED_W +: SPEED_W]};
		alt_x     = {s_tdata[7*SPEED_W-1], s_tdata[6*SPEED_W +: SPEED_W]};
		lim_x     = {2'b00, angle_limit_q};
		lim_neg   = -lim_x;
		alt_lim_x = {2'b00, altitude_limit_q};
		chk_d.limit_bad = (roll_x > lim_x) || (roll_x < lim_neg) ||
			(pitch_x > lim_x) || (pitch_x < lim_neg) || (alt_x > alt_lim_x);
		chk_d.stop = s_tuser;
	end

	// Stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			sum_s1   <= sum_d;
			roll_s1  <= s_tdata[4*SPEED_W +: SPEED_W];
			pitch_s1 <= s_tdata[5*SPEED_W +: SPEED_W];
			vx_s1    <= s_tdata[7*SPEED_W +: SPEED_W];
			vy_s1    <= s_tdata[8*SPEED_W +: SPEED_W];
			vz_s1    <= s_tdata[9*SPEED_W +: SPEED_W];
			chk_s1   <= chk_d;
		end
	end

	// Mean is the sum shifted arithmetically right by two
	assign mean = sum_s1[SPEED_W+1:2];

	for (genvar g = 0; g < N_LANES; g++) begin : g_lane
		msm_lane u_lane (
			.clk             (clk),
			.load            (load_s1),
			.speed           (speed_in[g]),
			.speed_max       (speed_max_q),
			.mean            (mean),
			.imbalance_limit (imbalance_limit_q),
			.clamp           (clamp[g]),
			.flags           (lane_flags[g])
		);
	end

	msm_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (load_out),
		.lane_flags  (lane_flags),
		.chk         (chk_s1),
		.error_limit (error_limit_q),
		.verdict     (verdict)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			for (int i = 0; i < N_LANES; i++) begin
				out_speed_q[i] <= verdict.shut ? '0 : clamp[i];
			end
			out_roll_q  <= verdict.shut ? '0 : roll_s1;
			out_pitch_q <= verdict.shut ? '0 : pitch_s1;
			out_vx_q    <= verdict.shut ? '0 : vx_s1;
			out_vy_q    <= verdict.shut ? '0 : vy_s1;
			out_vz_q    <= verdict.shut ? '0 : vz_s1;
			out_shut_q  <= verdict.shut;
		end
	end

	// Pack the result beat
	assign m_tdata = {4'b0000, out_vz_q, out_vy_q, out_vx_q, out_pitch_q, out_roll_q,
		out_speed_q[3], out_speed_q[2], out_speed_q[1], out_speed_q[0]};
	assign m_tuser  = out_shut_q;
	assign m_tvalid = out_valid_q;

	`MSM_ASSERT_NEXT(a_hold_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result beat changed under stall")
	`MSM_ASSERT_NEXT(a_s1_to_out, v_s1 && out_ready, m_tvalid, "stage 1 beat did not reach the output")
	`MSM_ASSERT(a_shut_zero, m_tvalid && m_tuser, m_tdata == '0, "shutdown beat carries nonzero data")

endmodule

`default_nettype wire

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for motor_safety_monitor_top. Beats are sent on the
// slave stream and each one is run through a local copy of the limit checks,
// the fault counter and the shutdown rule. Output beats are compared field by
// field, in order, while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

	import msm_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES = 40;

	// One input beat, laid out as on s_tdata (first field in the low bits)
	typedef struct packed {
		logic [15:0] vel_z;
		logic [15:0] vel_y;
		logic [15:0] vel_x;
		logic [15:0] alt;
		logic [15:0] pitch;
		logic [15:0] roll;
		logic [15:0] spd_rr;
		logic [15:0] spd_rl;
		logic [15:0] spd_fr;
		logic [15:0] spd_fl;
	} sample_t;

	// One output beat: shutdown flag over the m_tdata payload
	typedef struct packed {
		logic        shut;
		logic [15:0] vel_z;
		logic [15:0] vel_y;
		logic [15:0] vel_x;
		logic [15:0] pitch;
		logic [15:0] roll;
		logic [14:0] spd_rr;
		logic [14:0] spd_rl;
		logic [14:0] spd_fr;
		logic [14:0] spd_fl;
	} safe_out_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic [IN_W-1:0]      s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [OUT_W-1:0]     m_tdata;
	logic                 m_tuser;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [IDX_W-1:0]     cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	// Local copy of the limits and the fault counter
	logic [LIMIT_W-1:0]   lim_angle;
	logic [LIMIT_W-1:0]   lim_alt;
	logic [LIMIT_W-1:0]   spd_max;
	logic [IMBAL_W-1:0]   lim_imbal;
	logic [ELIM_W-1:0]    lim_err;
	logic [COUNT_W-1:0]   flt_cnt;

	safe_out_t            safe_q[$];
	safe_out_t            got_beat;
	safe_out_t            want_beat;
	int                   errors = 0;
	int                   cycles = 0;
	bit                   idle_on = 1'b1;
	bit                   hold_req = 1'b0;
	int                   hold_left = 0;
	int                   stall_left = 0;

	motor_safety_monitor_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int rnd(int lo, int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int clip(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Work out the safe outputs of one beat and advance the fault counter
	function automatic safe_out_t guard_sample(sample_t it, logic stop);
		safe_out_t r;
		int sp[4];
		int sum;
		int mean;
		int maxd;
		int d;
		int roll;
		int pitch;
		int alt;
		int lim;
		int v;
		bit bad_spd;
		bit fault;
		bit shut;
		sp[0] = int'($signed(it.spd_fl));
		sp[1] = int'($signed(it.spd_fr));
		sp[2] = int'($signed(it.spd_rl));
		sp[3] = int'($signed(it.spd_rr));
		roll = int'($signed(it.roll));
		pitch = int'($signed(it.pitch));
		alt = int'($signed(it.alt));
		lim = int'(lim_angle);
		sum = 0;
		bad_spd = 1'b0;
		for (int k = 0; k < N_LANES; k++) begin
			sum += sp[k];
			if (sp[k] < 0 || sp[k] > int'(spd_max)) bad_spd = 1'b1;
		end
		mean = sum >>> 2;
		maxd = 0;
		for (int k = 0; k < N_LANES; k++) begin
			d = (sp[k] > mean) ? sp[k] - mean : mean - sp[k];
			if (d > maxd) maxd = d;
		end
		fault = roll > lim || roll < -lim || pitch > lim || pitch < -lim ||
			alt > int'(lim_alt) || bad_spd || maxd > int'(lim_imbal) || stop;
		shut = 1'b0;
		if (fault) begin
			if (flt_cnt != CNT_MAX) flt_cnt++;
			shut = (flt_cnt >= lim_err) || stop;
		end else if (flt_cnt != 0) begin
			flt_cnt--;
		end
		// Zero on shutdown, clamp otherwise
		for (int k = 0; k < N_LANES; k++) begin
			v = shut ? 0 : clip(sp[k], 0, int'(spd_max));
			case (k)
				0: r.spd_fl = v[14:0];
				1: r.spd_fr = v[14:0];
				2: r.spd_rl = v[14:0];
				default: r.spd_rr = v[14:0];
			endcase
		end
		r.roll = shut ? 16'h0 : it.roll;
		r.pitch = shut ? 16'h0 : it.pitch;
		r.vel_x = shut ? 16'h0 : it.vel_x;
		r.vel_y = shut ? 16'h0 : it.vel_y;
		r.vel_z = shut ? 16'h0 : it.vel_z;
		r.shut = shut;
		return r;
	endfunction

	function automatic sample_t mk(int fl, int fr, int rl, int rr, int roll, int pitch, int alt);
		sample_t it;
		it.spd_fl = fl[15:0];
		it.spd_fr = fr[15:0];
		it.spd_rl = rl[15:0];
		it.spd_rr = rr[15:0];
		it.roll = roll[15:0];
		it.pitch = pitch[15:0];
		it.alt = alt[15:0];
		it.vel_x = 16'($urandom);
		it.vel_y = 16'($urandom);
		it.vel_z = 16'($urandom);
		return it;
	endfunction

	// Send one beat, with an optional idle burst in front
	task automatic send_sample(sample_t it, logic stop);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tdata <= it;
		s_tuser <= stop;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		safe_q.push_back(guard_sample(it, stop));
	endtask

	// Write one register; lower valid after the last write of a batch
	task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val, bit last);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_ANGLE_LIMIT:     lim_angle = val[LIMIT_W-1:0];
			REG_ALTITUDE_LIMIT:  lim_alt = val[LIMIT_W-1:0];
			REG_SPEED_MAX:       spd_max = val[LIMIT_W-1:0];
			REG_IMBALANCE_LIMIT: lim_imbal = val[IMBAL_W-1:0];
			REG_ERROR_LIMIT:     lim_err = val[ELIM_W-1:0];
			default: ;
		endcase
		if (last) cfg_valid <= 1'b0;
	endtask

	task automatic set_limits(int angle, int alt, int smax, int imbal, int elim);
		cfg_write(REG_ANGLE_LIMIT, angle[CFG_W-1:0], 1'b0);
		cfg_write(REG_ALTITUDE_LIMIT, alt[CFG_W-1:0], 1'b0);
		cfg_write(REG_SPEED_MAX, smax[CFG_W-1:0], 1'b0);
		cfg_write(REG_IMBALANCE_LIMIT, imbal[CFG_W-1:0], 1'b0);
		cfg_write(REG_ERROR_LIMIT, elim[CFG_W-1:0], 1'b1);
	endtask

	// Stop sending and wait until every expected beat is out
	task automatic drain();
		s_tvalid <= 1'b0;
		while (safe_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Build a beat that mostly stays inside the limits, with an optional fault
	task automatic gen_sample(int fault_pct, int noise_pct, output sample_t it,
			output logic stop);
		int sp[4];
		int smax;
		int lim;
		int base;
		int spread;
		int k;
		smax = int'(spd_max);
		lim = int'(lim_angle);
		stop = 1'b0;
		if (rnd(0, 99) < noise_pct) begin
			it = {$urandom, $urandom, $urandom, $urandom, $urandom};
			stop = ($urandom_range(0, 15) == 0);
			return;
		end
		base = rnd(0, smax);
		spread = clip(int'(lim_imbal) / 3, 0, 4000);
		for (k = 0; k < N_LANES; k++) sp[k] = clip(base + rnd(-spread, spread), 0, smax);
		it = mk(sp[0], sp[1], sp[2], sp[3], rnd(-lim, lim), rnd(-lim, lim),
			rnd(-32768, int'(lim_alt)));
		if (rnd(0, 99) >= fault_pct) return;
		k = rnd(0, 3);
		case ($urandom_range(0, 6))
			0: it.roll = (lim < 32767) ? 16'(rnd(lim + 1, 32767)) : 16'h8000;
			1: it.pitch = 16'(rnd(-32768, -lim - 1));
			2: if (lim_alt < 15'h7FFF) it.alt = 16'(rnd(int'(lim_alt) + 1, 32767));
			3: sp[k] = rnd(-32768, -1);
			4: if (smax < 32767) sp[k] = rnd(smax + 1, 32767);
			5: sp[k] = rnd(-32768, 32767);
			default: stop = ($urandom_range(0, 2) == 0);
		endcase
		it.spd_fl = sp[0][15:0];
		it.spd_fr = sp[1][15:0];
		it.spd_rl = sp[2][15:0];
		it.spd_rr = sp[3][15:0];
		if (k == 0 && $urandom_range(0, 1) == 1) it.spd_fl = 16'($urandom);
	endtask

	task automatic run_random(int n, int fault_pct, int noise_pct);
		sample_t it;
		logic stop;
		for (int k = 0; k < n; k++) begin
			gen_sample(fault_pct, noise_pct, it, stop);
			send_sample(it, stop);
		end
	endtask

	// Output side: random stall bursts and the long hold-off
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 2);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			errors++;
		end
	endtask

	// Compare each output beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			got_beat = {m_tuser, m_tdata[$bits(safe_out_t)-2:0]};
			if (safe_q.size() == 0) begin
				$display("%0t: unexpected beat: expected none, actual %h", $time, got_beat);
				errors++;
			end else begin
				want_beat = safe_q.pop_front();
				check_field("out_front_left", want_beat.spd_fl, got_beat.spd_fl);
				check_field("out_front_right", want_beat.spd_fr, got_beat.spd_fr);
				check_field("out_rear_left", want_beat.spd_rl, got_beat.spd_rl);
				check_field("out_rear_right", want_beat.spd_rr, got_beat.spd_rr);
				check_field("out_roll", want_beat.roll, got_beat.roll);
				check_field("out_pitch", want_beat.pitch, got_beat.pitch);
				check_field("out_vel_x", want_beat.vel_x, got_beat.vel_x);
				check_field("out_vel_y", want_beat.vel_y, got_beat.vel_y);
				check_field("out_vel_z", want_beat.vel_z, got_beat.vel_z);
				check_field("shutdown", want_beat.shut, got_beat.shut);
			end
		end
	end

	// Reset limits: boundaries of every check, extremes, stop request
	task automatic test_reset_limits();
		send_sample(mk(12800, 12800, 12800, 12800, 0, 0, 0), 1'b0);
		send_sample(mk(12800, 12800, 12800, 12800, 3215, -3215, 1600), 1'b0);
		send_sample(mk(12800, 12800, 12800, 12800, 3216, 0, 0), 1'b0);
		send_sample(mk(12800, 12800, 12800, 12800, 0, -3216, 0), 1'b0);
		send_sample(mk(12800, 12800, 12800, 12800, 0, 0, 1601), 1'b0);
		send_sample(mk(-1, 0, 0, 0, 0, 0, 0), 1'b0);
		send_sample(mk(25601, 25600, 25600, 25600, 0, 0, -32768), 1'b0);
		send_sample(mk(25600, 25600, 25600, 25600, 0, 0, 0), 1'b0);
		send_sample(mk(10000, 10000, 10000, 20000, 0, 0, 0), 1'b0);
		send_sample(mk(10000, 10000, 10000, 21000, 0, 0, 0), 1'b0);
		// Negative sum rounds the mean down
		send_sample(mk(-1, -2, 0, 0, 0, 0, 0), 1'b0);
		send_sample(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1);
		send_sample(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768), 1'b0);
		send_sample(mk(12800, 12800, 12800, 12800, 0, 0, 0), 1'b1);
		drain();
	endtask

	// Low error limit: shutdown on the count, then clean beats at a high count
	task automatic test_error_limit();
		set_limits(3215, 1600, 25600, 7680, 3);
		for (int k = 0; k < 4; k++) send_sample(mk(-5, 100, 100, 100, 0, 0, 0), 1'b0);
		send_sample(mk(6400, 6400, 6400, 6400, 100, -100, 10), 1'b0);
		send_sample(mk(6400, 6400, 6400, 6400, 100, -100, 10), 1'b0);
		send_sample(mk(0, 0, 0, 0, 0, 0, 0), 1'b0);
		drain();
	endtask

	// Unmapped indexes, an oversized value and an error limit of zero
	task automatic test_register_edges();
		for (int k = REG_ERROR_LIMIT + 1; k < (1 << IDX_W); k++)
			cfg_write(k[IDX_W-1:0], 16'h0001, 1'b0);
		cfg_write(REG_SPEED_MAX, 16'hFFFF, 1'b0);
		cfg_write(REG_ERROR_LIMIT, 16'h0000, 1'b1);
		send_sample(mk(32767, 32767, 32767, 32767, 0, 0, 0), 1'b0);
		send_sample(mk(32767, 32767, 32767, -1, 0, 0, 0), 1'b0);
		send_sample(mk(32767, 32767, 32767, 32767, 0, 0, 0), 1'b0);
		drain();
	endtask

	// Drive the counter into saturation, then bring it down
	task automatic test_saturation();
		set_limits(3215, 1600, 25600, 7680, 255);
		run_random(270, 100, 0);
		run_random(20, 0, 0);
		drain();
	endtask

	// Hold the output off while beats keep coming, then pause until empty
	task automatic test_backpressure();
		set_limits(3215, 1600, 25600, 7680, 10);
		idle_on = 1'b0;
		hold_req = 1'b1;
		run_random(40, 40, 10);
		idle_on = 1'b1;
		drain();
		run_random(20, 40, 10);
		drain();
	endtask

	// Random beats over several limit settings, extremes among them
	task automatic test_random();
		set_limits(0, 0, 0, 0, 1);
		run_random(110, 30, 15);
		drain();
		set_limits(32767, 32767, 32767, 65535, 255);
		run_random(110, 50, 15);
		drain();
		set_limits(3215, 1600, 25600, 7680, 10);
		run_random(120, 60, 10);
		drain();
		for (int k = 0; k < 4; k++) begin
			set_limits(rnd(0, 32767), rnd(0, 32767), rnd(0, 32767), rnd(0, 65535),
				rnd(1, 20));
			run_random(110, rnd(20, 70), 15);
			drain();
		end
		// Last stretch runs with no idling on either side
		idle_on = 1'b0;
		set_limits(rnd(0, 32767), rnd(0, 32767), rnd(0, 32767), rnd(0, 65535), rnd(1, 12));
		run_random(100, 55, 10);
		drain();
	endtask

	initial begin
		lim_angle = ANGLE_LIMIT_RST;
		lim_alt = ALTITUDE_LIMIT_RST;
		spd_max = SPEED_MAX_RST;
		lim_imbal = IMBALANCE_LIMIT_RST;
		lim_err = ERROR_LIMIT_RST;
		flt_cnt = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_reset_limits();
		test_error_limit();
		test_register_edges();
		test_saturation();
		test_backpressure();
		test_random();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
+incdir+rtl
rtl/msm_pkg.sv
rtl/msm_lane.sv
rtl/msm_merge.sv
rtl/motor_safety_monitor_top.sv
test/tb.sv
